// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the mapper block.
// Each macro builds one labeled concurrent assertion on a clock and a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cbm_pkg.sv =====
// Types and decode constants for the cartridge bank mapper with scanline IRQ.
// No dependencies; used by the top level and its checker.
package cbm_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] target_slot;
    logic [7:0] bank_number;
    logic [1:0] mirror_mode;
    logic       irq_pulse;
  } result_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_PRG    = 2'd1;
  localparam logic [1:0] ACT_CHR    = 2'd2;
  localparam logic [1:0] ACT_MIRROR = 2'd3;

  localparam logic [15:0] ADDR_PRG0     = 16'h8000;
  localparam logic [15:0] ADDR_PRG1     = 16'hA000;
  localparam logic [15:0] ADDR_MIRROR   = 16'h9000;
  localparam logic [15:0] ADDR_SWAP     = 16'h9002;
  localparam logic [15:0] ADDR_LATCH_LO = 16'hF000;
  localparam logic [15:0] ADDR_LATCH_HI = 16'hF002;
  localparam logic [15:0] ADDR_LATCH_HA = 16'hF040;
  localparam logic [15:0] ADDR_CTRL     = 16'hF001;
  localparam logic [15:0] ADDR_CTRL_A   = 16'hF004;
  localparam logic [15:0] ADDR_CTRL_B   = 16'hF080;
  localparam logic [15:0] ADDR_ACK      = 16'hF003;
  localparam logic [15:0] ADDR_ACK_A    = 16'hF006;
  localparam logic [15:0] ADDR_ACK_B    = 16'hF0C0;

  // Character register pages and in-page offsets.
  localparam logic [3:0]  CHR_PAGE_FIRST = 4'hB;
  localparam logic [3:0]  CHR_PAGE_LAST  = 4'hE;
  localparam logic [11:0] CHR_EVEN_LO    = 12'h000;
  localparam logic [11:0] CHR_EVEN_HI    = 12'h002;
  localparam logic [11:0] CHR_EVEN_HI_A  = 12'h040;
  localparam logic [11:0] CHR_ODD_LO     = 12'h001;
  localparam logic [11:0] CHR_ODD_LO_A   = 12'h004;
  localparam logic [11:0] CHR_ODD_LO_B   = 12'h080;
  localparam logic [11:0] CHR_ODD_HI     = 12'h003;
  localparam logic [11:0] CHR_ODD_HI_A   = 12'h006;
  localparam logic [11:0] CHR_ODD_HI_B   = 12'h0C0;

  localparam logic [2:0] PRG_SLOT_8000 = 3'd0;
  localparam logic [2:0] PRG_SLOT_A000 = 3'd1;
  localparam logic [2:0] PRG_SLOT_C000 = 3'd2;

  localparam int CHR_SLOTS = 8;

endpackage

// ===== rtl/core/cartridge_bank_mapper_scanline_irq.sv =====
// Cartridge bank mapper: CPU write decode, character nibble banks, scanline IRQ.
// Depends on cbm_pkg for payload types and decode constants.
// A result word is valid in the cycle after its item word is accepted.
// Throughput: one item per cycle while each result word is taken; the output register frees as it is taken.
// Reset (rst, synchronous, active high) clears all bank, latch and IRQ state
// and empties the output register.
module cartridge_bank_mapper_scanline_irq (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  cbm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output cbm_pkg::result_t result
);

  logic       swap_mode, swap_mode_next;
  logic [3:0] chr_low_nibble  [cbm_pkg::CHR_SLOTS];
  logic [3:0] chr_high_nibble [cbm_pkg::CHR_SLOTS];
  logic [7:0] irq_reload, irq_reload_next;
  logic [7:0] irq_count, irq_count_next;
  logic       irq_on, irq_on_next;
  logic       irq_rearm, irq_rearm_next;

  cbm_pkg::result_t result_next;

  logic        accept;
  logic [3:0]  page;
  logic [11:0] offset;
  logic        chr_hit, chr_odd, chr_high;
  logic [1:0]  page_idx;
  logic [2:0]  chr_slot;
  logic [3:0]  nib;
  logic [3:0]  chr_lo_new, chr_hi_new;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign page     = item.address[15:12];
  assign offset   = item.address[11:0];
  assign page_idx = 2'(page - cbm_pkg::CHR_PAGE_FIRST);
  assign chr_slot = {page_idx, chr_odd};
  assign nib      = item.data_byte[3:0];

  always_comb begin
    chr_hit  = (page >= cbm_pkg::CHR_PAGE_FIRST) && (page <= cbm_pkg::CHR_PAGE_LAST);
    chr_odd  = 1'b0;
    chr_high = 1'b0;
    unique case (offset)
      cbm_pkg::CHR_EVEN_LO: begin
        chr_odd = 1'b0; chr_high = 1'b0;
      end
      cbm_pkg::CHR_EVEN_HI, cbm_pkg::CHR_EVEN_HI_A: begin
        chr_odd = 1'b0; chr_high = 1'b1;
      end
      cbm_pkg::CHR_ODD_LO, cbm_pkg::CHR_ODD_LO_A, cbm_pkg::CHR_ODD_LO_B: begin
        chr_odd = 1'b1; chr_high = 1'b0;
      end
      cbm_pkg::CHR_ODD_HI, cbm_pkg::CHR_ODD_HI_A, cbm_pkg::CHR_ODD_HI_B: begin
        chr_odd = 1'b1; chr_high = 1'b1;
      end
      default: chr_hit = 1'b0;
    endcase
  end

  // Reported bank uses the nibble being written this cycle.
  assign chr_lo_new = chr_high ? chr_low_nibble[chr_slot] : nib;
  assign chr_hi_new = chr_high ? nib : chr_high_nibble[chr_slot];

  always_comb begin
    swap_mode_next  = swap_mode;
    irq_reload_next = irq_reload;
    irq_count_next  = irq_count;
    irq_on_next     = irq_on;
    irq_rearm_next  = irq_rearm;
    result_next     = '0;

    if (item.kind == cbm_pkg::KIND_TICK) begin
      if (irq_on) begin
        if (irq_count == 8'hFF) begin
          // Overflow: reload, pulse, rearm from the wait bit.
          irq_count_next        = irq_reload;
          irq_on_next           = irq_rearm;
          result_next.irq_pulse = 1'b1;
        end else begin
          irq_count_next = irq_count + 8'd1;
        end
      end
    end else if (chr_hit) begin
      result_next.action      = cbm_pkg::ACT_CHR;
      result_next.target_slot = chr_slot;
      result_next.bank_number = {chr_hi_new, chr_lo_new};
    end else begin
      unique case (item.address)
        cbm_pkg::ADDR_PRG0: begin
          result_next.action      = cbm_pkg::ACT_PRG;
          result_next.target_slot = swap_mode ? cbm_pkg::PRG_SLOT_C000
                                              : cbm_pkg::PRG_SLOT_8000;
          result_next.bank_number = item.data_byte;
        end
        cbm_pkg::ADDR_PRG1: begin
          result_next.action      = cbm_pkg::ACT_PRG;
          result_next.target_slot = cbm_pkg::PRG_SLOT_A000;
          result_next.bank_number = item.data_byte;
        end
        cbm_pkg::ADDR_MIRROR: begin
          result_next.action      = cbm_pkg::ACT_MIRROR;
          result_next.mirror_mode = item.data_byte[1:0];
        end
        cbm_pkg::ADDR_SWAP: swap_mode_next = item.data_byte[1];
        cbm_pkg::ADDR_LATCH_LO: irq_reload_next = {irq_reload[7:4], nib};
        cbm_pkg::ADDR_LATCH_HI, cbm_pkg::ADDR_LATCH_HA:
          irq_reload_next = {nib, irq_reload[3:0]};
        cbm_pkg::ADDR_CTRL, cbm_pkg::ADDR_CTRL_A, cbm_pkg::ADDR_CTRL_B: begin
          irq_on_next    = item.data_byte[1];
          irq_rearm_next = item.data_byte[0];
          irq_count_next = irq_reload;
        end
        cbm_pkg::ADDR_ACK, cbm_pkg::ADDR_ACK_A, cbm_pkg::ADDR_ACK_B:
          irq_on_next = irq_rearm;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_mode    <= 1'b0;
      irq_reload   <= '0;
      irq_count    <= '0;
      irq_on       <= 1'b0;
      irq_rearm    <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
        chr_low_nibble[i]  <= '0;
        chr_high_nibble[i] <= '0;
      end
    end else begin
      if (accept) begin
        swap_mode  <= swap_mode_next;
        irq_reload <= irq_reload_next;
        irq_count  <= irq_count_next;
        irq_on     <= irq_on_next;
        irq_rearm  <= irq_rearm_next;
        if (item.kind == cbm_pkg::KIND_WRITE && chr_hit) begin
          if (chr_high) chr_high_nibble[chr_slot] <= nib;
          else          chr_low_nibble[chr_slot]  <= nib;
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload register: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) result <= result_next;
  end

endmodule

// ===== rtl/core/cbm_checker.sv =====
// Port-level checker for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbm_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input cbm_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input cbm_pkg::result_t result
);

  logic accept;
  assign accept = item_valid && item_ready;

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "stalled result word changed")
  `ASSERT_NEXT(a_result_follows, clk, rst, accept, result_valid, "accepted word gave no result")
  `ASSERT_NEXT(a_tick_silent, clk, rst, accept && item.kind == cbm_pkg::KIND_TICK, result.action == cbm_pkg::ACT_NONE, "tick reported an action")
  `ASSERT_NEXT(a_write_no_pulse, clk, rst, accept && item.kind == cbm_pkg::KIND_WRITE, !result.irq_pulse, "write raised irq pulse")
  `ASSERT_NEXT(a_mirror_set, clk, rst, accept && item.kind == cbm_pkg::KIND_WRITE && item.address == cbm_pkg::ADDR_MIRROR, result.action == cbm_pkg::ACT_MIRROR && result.mirror_mode == $past(item.data_byte[1:0]), "mirroring write misreported")

endmodule

bind cartridge_bank_mapper_scanline_irq cbm_checker u_cbm_checker (.*);

// ===== sim/cartridge_bank_mapper_scanline_irq_tb.sv =====
// Self-checking testbench for cartridge_bank_mapper_scanline_irq.
// Depends on cbm_pkg and the mapper RTL; it checks every result word against
// a cycle-free model of the decode, character nibbles and scanline counter.
`timescale 1ns / 100ps

module cartridge_bank_mapper_scanline_irq_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 555;
  localparam int REPORT_MAX = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  cbm_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  cbm_pkg::result_t result;

  cartridge_bank_mapper_scanline_irq dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Mapper model state.
  logic       swap_sel;
  logic [3:0] chr_lo_nib [cbm_pkg::CHR_SLOTS];
  logic [3:0] chr_hi_nib [cbm_pkg::CHR_SLOTS];
  logic [7:0] irq_latch;
  logic [7:0] irq_counter;
  logic       irq_enabled;
  logic       irq_rearm_bit;

  cbm_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      cycle_count = 0;

  // Sender pacing.
  int burst_left = 0;
  bit sender_steady = 1'b0;

  // Receiver long hold-off request, handed over by a toggle.
  int   hold_len = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   rx_phase = 0;

  logic [11:0] chr_offsets [10] = '{
    cbm_pkg::CHR_EVEN_LO, cbm_pkg::CHR_EVEN_HI, cbm_pkg::CHR_EVEN_HI_A,
    cbm_pkg::CHR_ODD_LO, cbm_pkg::CHR_ODD_LO_A, cbm_pkg::CHR_ODD_LO_B,
    cbm_pkg::CHR_ODD_HI, cbm_pkg::CHR_ODD_HI_A, cbm_pkg::CHR_ODD_HI_B,
    cbm_pkg::CHR_EVEN_LO};
  logic [15:0] irq_addrs [9] = '{
    cbm_pkg::ADDR_LATCH_LO, cbm_pkg::ADDR_LATCH_HI, cbm_pkg::ADDR_LATCH_HA,
    cbm_pkg::ADDR_CTRL, cbm_pkg::ADDR_CTRL_A, cbm_pkg::ADDR_CTRL_B,
    cbm_pkg::ADDR_ACK, cbm_pkg::ADDR_ACK_A, cbm_pkg::ADDR_ACK_B};
  logic [15:0] cpu_addrs [4] = '{
    cbm_pkg::ADDR_PRG0, cbm_pkg::ADDR_PRG1, cbm_pkg::ADDR_MIRROR, cbm_pkg::ADDR_SWAP};

  initial forever #1 clk = ~clk;

  function automatic void clear_mapper();
    swap_sel = 1'b0;
    for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
      chr_lo_nib[i] = '0;
      chr_hi_nib[i] = '0;
    end
    irq_latch = '0;
    irq_counter = '0;
    irq_enabled = 1'b0;
    irq_rearm_bit = 1'b0;
  endfunction

  // Advance the mapper model by one word and return the word it reports.
  function automatic cbm_pkg::result_t decode_word(cbm_pkg::item_t w);
    cbm_pkg::result_t r;
    logic [3:0]  page;
    logic [11:0] offs;
    logic [2:0]  slot;
    logic        hit;
    logic        odd;
    logic        hi_nib;
    r = '0;
    page = w.address[15:12];
    offs = w.address[11:0];
    hit = 1'b0;
    odd = 1'b0;
    hi_nib = 1'b0;
    if (page >= cbm_pkg::CHR_PAGE_FIRST && page <= cbm_pkg::CHR_PAGE_LAST) begin
      case (offs)
        cbm_pkg::CHR_EVEN_LO: hit = 1'b1;
        cbm_pkg::CHR_EVEN_HI, cbm_pkg::CHR_EVEN_HI_A: begin
          hit = 1'b1;
          hi_nib = 1'b1;
        end
        cbm_pkg::CHR_ODD_LO, cbm_pkg::CHR_ODD_LO_A, cbm_pkg::CHR_ODD_LO_B: begin
          hit = 1'b1;
          odd = 1'b1;
        end
        cbm_pkg::CHR_ODD_HI, cbm_pkg::CHR_ODD_HI_A, cbm_pkg::CHR_ODD_HI_B: begin
          hit = 1'b1;
          odd = 1'b1;
          hi_nib = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
    slot = 3'(((page - cbm_pkg::CHR_PAGE_FIRST) << 1) | odd);

    if (w.kind == cbm_pkg::KIND_TICK) begin
      if (irq_enabled) begin
        if (irq_counter == 8'hFF) begin
          irq_counter = irq_latch;
          r.irq_pulse = 1'b1;
          irq_enabled = irq_rearm_bit;
        end else begin
          irq_counter = irq_counter + 8'd1;
        end
      end
    end else if (hit) begin
      if (hi_nib) chr_hi_nib[slot] = w.data_byte[3:0];
      else chr_lo_nib[slot] = w.data_byte[3:0];
      r.action = cbm_pkg::ACT_CHR;
      r.target_slot = slot;
      r.bank_number = {chr_hi_nib[slot], chr_lo_nib[slot]};
    end else begin
      case (w.address)
        cbm_pkg::ADDR_PRG0: begin
          r.action = cbm_pkg::ACT_PRG;
          r.target_slot = swap_sel ? cbm_pkg::PRG_SLOT_C000 : cbm_pkg::PRG_SLOT_8000;
          r.bank_number = w.data_byte;
        end
        cbm_pkg::ADDR_PRG1: begin
          r.action = cbm_pkg::ACT_PRG;
          r.target_slot = cbm_pkg::PRG_SLOT_A000;
          r.bank_number = w.data_byte;
        end
        cbm_pkg::ADDR_MIRROR: begin
          r.action = cbm_pkg::ACT_MIRROR;
          r.mirror_mode = w.data_byte[1:0];
        end
        cbm_pkg::ADDR_SWAP: swap_sel = w.data_byte[1];
        cbm_pkg::ADDR_LATCH_LO: irq_latch[3:0] = w.data_byte[3:0];
        cbm_pkg::ADDR_LATCH_HI, cbm_pkg::ADDR_LATCH_HA: irq_latch[7:4] = w.data_byte[3:0];
        cbm_pkg::ADDR_CTRL, cbm_pkg::ADDR_CTRL_A, cbm_pkg::ADDR_CTRL_B: begin
          irq_enabled = w.data_byte[1];
          irq_rearm_bit = w.data_byte[0];
          irq_counter = irq_latch;
        end
        cbm_pkg::ADDR_ACK, cbm_pkg::ADDR_ACK_A, cbm_pkg::ADDR_ACK_B:
          irq_enabled = irq_rearm_bit;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Offer one word, hold it until taken, then pace the next one.
  task automatic send_word(input logic kind, input logic [15:0] addr,
                           input logic [7:0] data);
    cbm_pkg::item_t w;
    int    gap;
    w.kind = kind;
    w.address = addr;
    w.data_byte = data;
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(decode_word(w));
    if (!sender_steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  task automatic write_reg(input logic [15:0] addr, input logic [7:0] data);
    send_word(cbm_pkg::KIND_WRITE, addr, data);
  endtask

  task automatic tick();
    send_word(cbm_pkg::KIND_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic send_random_word();
    int          pick;
    logic [15:0] addr;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    data = 8'($urandom);
    if (pick < 35) begin
      tick();
    end else if (pick < 50) begin
      addr = {4'($urandom_range(cbm_pkg::CHR_PAGE_FIRST, cbm_pkg::CHR_PAGE_LAST)),
              chr_offsets[$urandom_range(0, 9)]};
      write_reg(addr, data);
    end else if (pick < 62) begin
      write_reg(cpu_addrs[$urandom_range(0, 3)], data);
    end else if (pick < 85) begin
      addr = irq_addrs[$urandom_range(0, 8)];
      // Keep the latch near the top and the counter mostly on, so wraps come often.
      if ((addr == cbm_pkg::ADDR_LATCH_HI || addr == cbm_pkg::ADDR_LATCH_HA) &&
          $urandom_range(0, 9) < 7)
        data[3:0] = 4'hF;
      if ((addr == cbm_pkg::ADDR_CTRL || addr == cbm_pkg::ADDR_CTRL_A ||
           addr == cbm_pkg::ADDR_CTRL_B) && $urandom_range(0, 3) != 0)
        data[1] = 1'b1;
      write_reg(addr, data);
    end else if (pick < 93) begin
      write_reg(16'($urandom), data);
    end else begin
      // Near miss: a decoded address with one bit flipped.
      addr = (pick & 1) ? irq_addrs[$urandom_range(0, 8)] : cpu_addrs[$urandom_range(0, 3)];
      addr[$urandom_range(0, 15)] ^= 1'b1;
      write_reg(addr, data);
    end
  endtask

  task automatic test_program_banks();
    write_reg(cbm_pkg::ADDR_PRG0, 8'h00);
    write_reg(cbm_pkg::ADDR_PRG0, 8'hFF);
    write_reg(cbm_pkg::ADDR_SWAP, 8'h02);
    write_reg(cbm_pkg::ADDR_PRG0, 8'hA5);
    write_reg(cbm_pkg::ADDR_PRG1, 8'h5A);
    write_reg(cbm_pkg::ADDR_SWAP, 8'hFD);
    write_reg(cbm_pkg::ADDR_MIRROR, 8'hFF);
    write_reg(cbm_pkg::ADDR_MIRROR, 8'h06);
  endtask

  task automatic test_char_banks();
    for (int i = 0; i < 10; i++)
      write_reg({4'(cbm_pkg::CHR_PAGE_FIRST + (i % 4)), chr_offsets[i]},
                (i & 1) ? 8'hF0 : 8'hFF);
  endtask

  task automatic test_scanline_irq();
    tick();
    write_reg(cbm_pkg::ADDR_LATCH_LO, 8'hFE);
    write_reg(cbm_pkg::ADDR_LATCH_HI, 8'h0F);
    write_reg(cbm_pkg::ADDR_CTRL, 8'h03);
    tick();
    tick();
    write_reg(cbm_pkg::ADDR_LATCH_HA, 8'hFF);
    write_reg(cbm_pkg::ADDR_LATCH_LO, 8'hFF);
    write_reg(cbm_pkg::ADDR_CTRL_B, 8'h02);
    tick();
    tick();
    write_reg(cbm_pkg::ADDR_CTRL_A, 8'h01);
    write_reg(cbm_pkg::ADDR_ACK_B, 8'h00);
    tick();
    write_reg(cbm_pkg::ADDR_ACK, 8'h00);
    write_reg(cbm_pkg::ADDR_ACK_A, 8'h00);
    write_reg(16'h0000, 8'hFF);
    write_reg(16'hFFFF, 8'h00);
  endtask

  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_len <= 300;
    hold_toggle <= ~hold_toggle;
    repeat (60) send_random_word();
    sender_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Switch between paced and back-to-back stretches at random.
      if (i % 100 == 0) sender_steady = ($urandom_range(0, 2) == 0);
      send_random_word();
    end
    sender_steady = 1'b0;
  endtask

  // Receiver: its own stall pattern, plus one long hold when asked.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= hold_len;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(30, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        2: result_ready <= (rx_phase % 7) < 4;
        default: result_ready <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  // Compare every taken result word against the oldest expectation.
  always @(posedge clk) begin
    cbm_pkg::result_t exp_word;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result word: action=%0d slot=%0d bank=%02h mirror=%0d irq=%0b",
                   result.action, result.target_slot, result.bank_number,
                   result.mirror_mode, result.irq_pulse);
        mismatches++;
      end else begin
        exp_word = pending_results.pop_front();
        if (result.action !== exp_word.action ||
            result.target_slot !== exp_word.target_slot ||
            result.bank_number !== exp_word.bank_number ||
            result.mirror_mode !== exp_word.mirror_mode ||
            result.irq_pulse !== exp_word.irq_pulse) begin
          if (mismatches < REPORT_MAX)
            $display({"mismatch: action %0d/%0d slot %0d/%0d bank %02h/%02h",
                      " mirror %0d/%0d irq %0b/%0b (expected/actual)"},
                     exp_word.action, result.action,
                     exp_word.target_slot, result.target_slot,
                     exp_word.bank_number, result.bank_number,
                     exp_word.mirror_mode, result.mirror_mode,
                     exp_word.irq_pulse, result.irq_pulse);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_mapper();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_program_banks();
    test_char_banks();
    test_scanline_irq();
    test_backpressure();
    test_random_traffic();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cbm_pkg.sv
rtl/core/cartridge_bank_mapper_scanline_irq.sv
rtl/core/cbm_checker.sv
sim/cartridge_bank_mapper_scanline_irq_tb.sv
